// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the positional list store RTL.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define PLS_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("pls assertion failed");

// Check a property on every rising edge, reset included.
`define PLS_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("pls assertion failed");

`endif

// ===== rtl/core/pls_pkg.sv =====
// Package for the positional list store: field widths, codes, command
// and status structs. No dependencies.
package pls_pkg;

  localparam int PLS_CAPACITY   = 32;
  localparam int PLS_DATA_WIDTH = 32;

  localparam int ACT_W   = 2;
  localparam int FIELD_W = 32;
  localparam int POS_W   = 7;
  localparam int LEN_W   = 7;
  localparam int ST_W    = 2;
  localparam int CMP_W   = POS_W + 1;

  localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
  localparam logic [ACT_W-1:0] ACT_DELETE = 2'd1;
  localparam logic [ACT_W-1:0] ACT_DUMP   = 2'd2;

  localparam logic [ST_W-1:0] ST_OK      = 2'd0;
  localparam logic [ST_W-1:0] ST_BAD_POS = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL    = 2'd2;
  localparam logic [ST_W-1:0] ST_EMPTY   = 2'd3;

  typedef struct packed {
    logic load_req;
    logic exec;
    logic dump_beat;
  } pls_cmd_t;

  typedef struct packed {
    logic is_dump;
    logic empty;
    logic dump_last;
  } pls_stat_t;

endpackage

// ===== rtl/core/positional_list_store_top.sv =====
// Top level of the positional list store: controller plus datapath.
// Depends on pls_pkg, pls_ctrl and pls_datapath.
//
//  channel | handshake           | payload
//  req     | req_valid/req_stall | action, value, position
//  rsp     | rsp_valid/rsp_stall | element, status, list_length, last
//
// Insert, delete and bad requests: accept loads the request register, then
// the cells from the position on shift at once (none if bad) and the response
// register loads. A dump rotates the occupied cells one place per beat and
// the head cell feeds the response register.
// Reset empties the list; cells hold no reset value and need no clearing.
// A stalled response holds its beat; a request may be taken while it waits.

module positional_list_store_top
  import pls_pkg::*;
#(
  parameter int CAPACITY   = PLS_CAPACITY,
  parameter int DATA_WIDTH = PLS_DATA_WIDTH
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      req_valid,
  output logic                      req_stall,
  input  logic [ACT_W-1:0]          action,
  input  logic signed [FIELD_W-1:0] value,
  input  logic [POS_W-1:0]          position,
  output logic                      rsp_valid,
  input  logic                      rsp_stall,
  output logic signed [FIELD_W-1:0] element,
  output logic [ST_W-1:0]           status,
  output logic [LEN_W-1:0]          list_length,
  output logic                      last
);

  pls_cmd_t  cmd;
  pls_stat_t stat;

  pls_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  pls_datapath #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .action      (action),
    .value       (value),
    .position    (position),
    .element     (element),
    .status      (status),
    .list_length (list_length),
    .last        (last)
  );

endmodule

// ===== rtl/core/pls_ctrl.sv =====
// Controller for the positional list store: request sequencing and
// response valid. Depends on pls_pkg and assert_macros.svh.
`include "assert_macros.svh"

module pls_ctrl
  import pls_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_stall,
  output logic      rsp_valid,
  input  logic      rsp_stall,
  input  pls_stat_t stat,
  output pls_cmd_t  cmd
);

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_DUMP} state_t;

  state_t state;
  logic   slot_free;

  assign req_stall = (state != S_IDLE);
  assign slot_free = !rsp_valid || !rsp_stall;

  assign cmd.load_req  = req_valid && (state == S_IDLE);
  assign cmd.exec      = (state == S_EXEC) && slot_free && !(stat.is_dump && !stat.empty);
  assign cmd.dump_beat = (state == S_DUMP) && slot_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd.load_req) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (stat.is_dump && !stat.empty) begin
            state <= S_DUMP;
          end else if (cmd.exec) begin
            rsp_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        S_DUMP: begin
          if (cmd.dump_beat) begin
            rsp_valid <= 1'b1;
            if (stat.dump_last) begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `PLS_ASSERT(a_accept_to_exec, clk, rst, cmd.load_req |=> state == S_EXEC)
  `PLS_ASSERT(a_dump_end, clk, rst, (cmd.dump_beat && stat.dump_last) |=> (state == S_IDLE && rsp_valid))
  `PLS_ASSERT(a_no_double_load, clk, rst, !(cmd.exec && cmd.dump_beat))

endmodule

// ===== rtl/core/pls_datapath.sv =====
// Datapath for the positional list store: request register, shifting
// cell row, entry count and response register. Depends on pls_pkg and assert_macros.svh.
`include "assert_macros.svh"

module pls_datapath
  import pls_pkg::*;
#(
  parameter int CAPACITY   = PLS_CAPACITY,
  parameter int DATA_WIDTH = PLS_DATA_WIDTH
) (
  input  logic                      clk,
  input  logic                      rst,
  input  pls_cmd_t                  cmd,
  output pls_stat_t                 stat,
  input  logic [ACT_W-1:0]          action,
  input  logic signed [FIELD_W-1:0] value,
  input  logic [POS_W-1:0]          position,
  output logic signed [FIELD_W-1:0] element,
  output logic [ST_W-1:0]           status,
  output logic [LEN_W-1:0]          list_length,
  output logic                      last
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CMP_W-1:0] CAP_CMP = CMP_W'(CAPACITY);

  logic [ACT_W-1:0]          req_action;
  logic signed [FIELD_W-1:0] req_value;
  logic [POS_W-1:0]          req_position;
  logic [CNT_W-1:0]          count;
  logic [CNT_W-1:0]          count_next;
  logic [CNT_W-1:0]          dump_idx;
  logic [CNT_W-1:0]          last_idx;
  logic [DATA_WIDTH-1:0]     cells [CAPACITY];
  logic [DATA_WIDTH-1:0]     word;
  logic [FIELD_W-1:0]        head_elem;
  logic [CMP_W-1:0]          pos_ext;
  logic [CMP_W-1:0]          cnt_ext;
  logic                      ins_bad, ins_full, del_bad;
  logic                      do_ins, do_del;
  logic [ST_W-1:0]           op_status;

  if (DATA_WIDTH > FIELD_W) begin : g_word_wide
    assign word = {{(DATA_WIDTH - FIELD_W){req_value[FIELD_W-1]}}, req_value};
  end else begin : g_word_narrow
    assign word = req_value[DATA_WIDTH-1:0];
  end

  if (DATA_WIDTH >= FIELD_W) begin : g_head_wide
    assign head_elem = cells[0][FIELD_W-1:0];
  end else begin : g_head_narrow
    assign head_elem = {{(FIELD_W - DATA_WIDTH){1'b0}}, cells[0]};
  end

  assign pos_ext  = {1'b0, req_position};
  assign cnt_ext  = CMP_W'(count);
  assign last_idx = count - 1'b1;

  assign ins_bad  = (pos_ext == '0) || (pos_ext > cnt_ext + 1'b1);
  assign ins_full = (cnt_ext == CAP_CMP);
  assign del_bad  = (pos_ext == '0) || (pos_ext > cnt_ext);
  assign do_ins   = cmd.exec && (req_action == ACT_INSERT) && !ins_bad && !ins_full;
  assign do_del   = cmd.exec && (req_action == ACT_DELETE) && !del_bad;

  assign stat.is_dump   = (req_action == ACT_DUMP);
  assign stat.empty     = (count == '0);
  assign stat.dump_last = ({1'b0, dump_idx} + 1'b1 == {1'b0, count});

  always_comb begin
    unique case (req_action)
      ACT_INSERT: op_status = ins_bad ? ST_BAD_POS : (ins_full ? ST_FULL : ST_OK);
      ACT_DELETE: op_status = del_bad ? ST_BAD_POS : ST_OK;
      ACT_DUMP:   op_status = ST_EMPTY;
      default:    op_status = ST_BAD_POS;
    endcase
  end

  always_comb begin
    priority if (do_ins) begin
      count_next = count + 1'b1;
    end else if (do_del) begin
      count_next = count - 1'b1;
    end else begin
      count_next = count;
    end
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    localparam logic [CMP_W-1:0] SLOT = CMP_W'(g + 1);
    localparam logic [CNT_W-1:0] IDX  = CNT_W'(g);
    logic [DATA_WIDTH-1:0] below;
    logic [DATA_WIDTH-1:0] above;
    logic [DATA_WIDTH-1:0] cell_next;

    if (g == 0) begin : g_first
      assign below = word;
    end else begin : g_inner_lo
      assign below = cells[g-1];
    end
    if (g == CAPACITY - 1) begin : g_final
      assign above = cells[0];
    end else begin : g_inner_hi
      assign above = cells[g+1];
    end

    always_comb begin
      cell_next = cells[g];
      priority if (do_ins) begin
        if (SLOT == pos_ext) begin
          cell_next = word;
        end else if (SLOT > pos_ext) begin
          cell_next = below;
        end
      end else if (do_del) begin
        if (SLOT >= pos_ext) begin
          cell_next = above;
        end
      end else if (cmd.dump_beat) begin
        if (IDX == last_idx) begin
          cell_next = cells[0];
        end else if (IDX < last_idx) begin
          cell_next = above;
        end
      end else begin
        cell_next = cells[g];
      end
    end

    always_ff @(posedge clk) begin
      cells[g] <= cell_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      dump_idx <= '0;
    end else begin
      count <= count_next;
      if (cmd.load_req) begin
        dump_idx <= '0;
      end else if (cmd.dump_beat) begin
        dump_idx <= dump_idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_action   <= action;
      req_value    <= value;
      req_position <= position;
    end
    if (cmd.exec) begin
      element     <= '0;
      status      <= op_status;
      list_length <= LEN_W'(count_next);
      last        <= 1'b1;
    end else if (cmd.dump_beat) begin
      element     <= head_elem;
      status      <= ST_OK;
      list_length <= LEN_W'(count);
      last        <= stat.dump_last;
    end
  end

  `PLS_ASSERT(a_count_bound, clk, rst, cnt_ext <= CAP_CMP)
  `PLS_ASSERT(a_dump_keeps_count, clk, rst, cmd.dump_beat |=> $stable(count))
  `PLS_ASSERT(a_insert_grows, clk, rst, do_ins |=> count == CNT_W'($past(count) + 1'b1))

endmodule
